// ===== rtl/core/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants for the framed packet receiver
// Result codes, reply codes, register indexes and frame position markers.
// ----------------------------------------------------------------------------
package frp_pkg;

	localparam int unsigned POS_W = 14;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;

	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NAK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

	localparam logic [7:0] START_MARKER_RST = 8'd2;
	localparam logic [7:0] END_MARKER_RST   = 8'd4;

	localparam logic [POS_W-1:0] POS_IDLE    = 14'd0;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 14'd1;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 14'd2;
	localparam logic [POS_W-1:0] POS_CMD     = 14'd3;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 14'd4;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data_byte;
		logic [6:0]       command_code;
		logic [LEN_W-1:0] frame_length;
		logic [1:0]       reply;
	} result_t;

endpackage

// ===== rtl/core/frp_parser.sv =====
// ----------------------------------------------------------------------------
// frp_parser: frame position tracking and result decode
// Holds the header fields and byte position; decodes one byte per step.
// ----------------------------------------------------------------------------
module frp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_marker,
	input  logic [7:0]          end_marker,
	output logic                emit,
	output frp_pkg::result_t    result
);
	import frp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [6:0]       len_lo_q;
	logic [5:0]       len_hi_q;
	logic             ack_q;
	logic [6:0]       cmd_q;
	logic [6:0]       csum_q;
	logic             ld_len_lo;
	logic             ld_len_hi;
	logic             ld_cmd;
	logic             ld_csum;
	logic [LEN_W-1:0] len;
	logic [POS_W-1:0] off;
	logic [POS_W-1:0] len_ext;
	logic [6:0]       sum;
	logic             good;

	assign len     = {len_hi_q, len_lo_q};
	assign len_ext = {1'b0, len};
	assign off     = pos_q - POS_PAYLOAD;
	assign sum     = len_lo_q + {ack_q, len_hi_q} + cmd_q;
	assign good    = (sum == csum_q);

	always_comb begin
		pos_next             = pos_q;
		emit                 = 1'b0;
		ld_len_lo            = 1'b0;
		ld_len_hi            = 1'b0;
		ld_cmd               = 1'b0;
		ld_csum              = 1'b0;
		result.kind          = KIND_PAYLOAD;
		result.data_byte     = 8'd0;
		result.command_code  = cmd_q;
		result.frame_length  = len;
		result.reply         = REPLY_NONE;
		if (pos_q == POS_IDLE) begin
			if (rx_byte == start_marker) pos_next = POS_LEN_LO;
		end else if (pos_q == POS_LEN_LO) begin
			ld_len_lo = 1'b1;
			pos_next  = POS_LEN_HI;
		end else if (pos_q == POS_LEN_HI) begin
			ld_len_hi = 1'b1;
			pos_next  = POS_CMD;
		end else if (pos_q == POS_CMD) begin
			ld_cmd   = 1'b1;
			pos_next = POS_PAYLOAD;
		end else if (off < len_ext) begin
			emit             = 1'b1;
			result.data_byte = rx_byte;
			pos_next         = pos_q + 14'd1;
		end else if (off == len_ext) begin
			ld_csum  = 1'b1;
			pos_next = pos_q + 14'd1;
		end else if (off == len_ext + 14'd1) begin
			if (rx_byte == end_marker) begin
				emit        = 1'b1;
				result.kind = good ? KIND_GOOD : KIND_BAD;
				if (ack_q) result.reply = good ? REPLY_ACK : REPLY_NAK;
				pos_next    = POS_IDLE;
			end
		end else begin
			pos_next = POS_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_IDLE;
			len_lo_q <= '0;
			len_hi_q <= '0;
			ack_q    <= 1'b0;
			cmd_q    <= '0;
			csum_q   <= '0;
		end else if (step) begin
			pos_q <= pos_next;
			if (ld_len_lo) len_lo_q <= rx_byte[6:0];
			if (ld_len_hi) begin
				len_hi_q <= rx_byte[5:0];
				ack_q    <= rx_byte[6];
			end
			if (ld_cmd) cmd_q <= rx_byte[6:0];
			if (ld_csum) csum_q <= rx_byte[6:0];
		end
	end

endmodule

// ===== rtl/core/framed_packet_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit: length-prefixed frame receiver, additive checksum
// Input register, decode, result register; one beat per cycle unless stalled.
// Throughput is set by the one-byte decode between the input and result
// registers; a byte that yields no result never waits on the output.
// Reset clears frame position, header fields and valid flags, and loads the
// marker registers with their defaults.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [7:0]                    data_byte,
	output logic [6:0]                    command_code,
	output logic [frp_pkg::LEN_W-1:0]     frame_length,
	output logic [1:0]                    reply
);
	import frp_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	logic       advance;
	logic       out_free;
	result_t    result;
	logic       valid_s2;
	result_t    result_s2;

	assign cfg_ready = 1'b1;
	assign out_free  = !valid_s2 || out_ready;
	assign advance   = valid_s1 && (!emit || out_free);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_START_MARKER) start_marker_q <= cfg_data;
			if (cfg_index == CFG_END_MARKER) end_marker_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= rx_byte;
	end

	frp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.rx_byte      (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.emit         (emit),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) result_s2 <= result;
	end

	assign out_valid    = valid_s2;
	assign kind         = result_s2.kind;
	assign data_byte    = result_s2.data_byte;
	assign command_code = result_s2.command_code;
	assign frame_length = result_s2.frame_length;
	assign reply        = result_s2.reply;

endmodule

// ===== rtl/core/frp_checker.sv =====
// ----------------------------------------------------------------------------
// frp_checker: port-level checks for the framed packet receiver
// Watches the result channel for handshake and result encoding rules.
// ----------------------------------------------------------------------------
module frp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                kind,
	input logic [7:0]                data_byte,
	input logic [frp_pkg::LEN_W-1:0] frame_length,
	input logic [1:0]                reply
);
	import frp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(frame_length) && $stable(reply))
		else $error("result beat changed while stalled");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_PAYLOAD || kind == KIND_GOOD || kind == KIND_BAD)
		else $error("unknown result kind");

	a_payload_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> reply == REPLY_NONE)
		else $error("reply on payload beat");

	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0)
		else $error("data on status beat");

	a_reply_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_GOOD |-> reply != REPLY_NAK)
		else $error("nak on good frame");

endmodule

bind framed_packet_receiver_unit frp_checker u_frp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.data_byte    (data_byte),
	.frame_length (frame_length),
	.reply        (reply)
);

// ===== sim/framed_packet_receiver_unit_test.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit_test: self-checking bench for the frame receiver
// Streams framed byte traffic through the receiver under several marker
// settings. Traffic is mostly well-formed frames with random content, mixed
// with idle noise and truncated frames. A tracker follows the frame position,
// predicts every payload and end-of-frame beat, and checks each result beat
// field by field as it leaves the block. Both sides stall at random.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit_test;
	import frp_pkg::*;

	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES   = 320;
	localparam int LONG_HOLD     = 250;

	class frame_tracker;
		logic [7:0]       start_mark;
		logic [7:0]       end_mark;
		logic [POS_W-1:0] position;
		logic [6:0]       len_lo;
		logic [5:0]       len_hi;
		logic             ack;
		logic [6:0]       cmd;
		logic [6:0]       csum;
		result_t          pending[$];
		int               errors;
		int               bytes_seen;
		int               payload_count;
		int               good_count;
		int               bad_count;

		function new();
			start_mark    = START_MARKER_RST;
			end_mark      = END_MARKER_RST;
			position      = POS_IDLE;
			len_lo        = '0;
			len_hi        = '0;
			ack           = 1'b0;
			cmd           = '0;
			csum          = '0;
			errors        = 0;
			bytes_seen    = 0;
			payload_count = 0;
			good_count    = 0;
			bad_count     = 0;
		endfunction

		function logic [LEN_W-1:0] frame_len();
			return {len_hi, len_lo};
		endfunction

		function bit awaiting_end();
			return position >= POS_PAYLOAD
				&& (position - POS_PAYLOAD) == {1'b0, frame_len()} + 14'd1;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			case (idx)
				CFG_START_MARKER: start_mark = value;
				CFG_END_MARKER:   end_mark = value;
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			logic [POS_W-1:0] offset;
			logic [POS_W-1:0] len_ext;
			logic [LEN_W-1:0] len;
			logic [6:0]       sum7;
			logic             good;
			bytes_seen++;
			len = frame_len();
			len_ext = {1'b0, len};
			offset = position - POS_PAYLOAD;
			case (position)
				POS_IDLE: if (b == start_mark) position = POS_LEN_LO;
				POS_LEN_LO: begin
					len_lo = b[6:0];
					position = POS_LEN_HI;
				end
				POS_LEN_HI: begin
					len_hi = b[5:0];
					ack = b[6];
					position = POS_CMD;
				end
				POS_CMD: begin
					cmd = b[6:0];
					position = POS_PAYLOAD;
				end
				default: begin
					if (offset < len_ext) begin
						pending.push_back(result_t'{KIND_PAYLOAD, b, cmd, len, REPLY_NONE});
						payload_count++;
						position = position + 14'd1;
					end else if (offset == len_ext) begin
						csum = b[6:0];
						position = position + 14'd1;
					end else if (offset == len_ext + 14'd1) begin
						if (b == end_mark) begin
							sum7 = len_lo + {ack, len_hi} + cmd;
							good = (sum7 == csum);
							pending.push_back(result_t'{good ? KIND_GOOD : KIND_BAD, 8'h00,
								cmd, len, ack ? (good ? REPLY_ACK : REPLY_NAK) : REPLY_NONE});
							if (good) good_count++;
							else bad_count++;
							position = POS_IDLE;
						end
					end else begin
						position = POS_IDLE;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result beat with nothing pending, kind %0d data %0d",
					$time, got.kind, got.data_byte);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("kind", 16'(want.kind), 16'(got.kind));
			compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
			compare_field("command_code", 16'(want.command_code), 16'(got.command_code));
			compare_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
			compare_field("reply", 16'(want.reply), 16'(got.reply));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           kind;
	logic [7:0]           data_byte;
	logic [6:0]           command_code;
	logic [LEN_W-1:0]     frame_length;
	logic [1:0]           reply;

	frame_tracker tracker = new();
	bit           gapless = 1'b0;
	bit           long_hold_req = 1'b0;
	int           sender_calm = 0;
	int           marker_settings = 1;

	framed_packet_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.command_code(command_code),
		.frame_length(frame_length),
		.reply(reply)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(result_t'({kind, data_byte, command_code, frame_length, reply}));
	end

	// receiver: short and long stalls, calm stretches, one long hold on request
	initial begin
		int stall_left;
		int calm_left;
		int r;
		stall_left = 0;
		calm_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				stall_left = LONG_HOLD;
			end else begin
				out_ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (calm_left > 0) calm_left--;
				else if (r < 12) stall_left = $urandom_range(1, 3);
				else if (r < 14) stall_left = $urandom_range(20, 60);
				else if (r < 16) calm_left = $urandom_range(50, 200);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("framed_packet_receiver_unit test failed");
		$finish;
	end

	function automatic int next_gap();
		int r;
		if (gapless) return 0;
		if (sender_calm > 0) begin
			sender_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			sender_calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 70) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] byte_other_than(logic [7:0] v);
		logic [7:0] x;
		x = 8'($urandom);
		if (x == v) x = x + 8'd1;
		return x;
	endfunction

	task automatic offer_byte(input logic [7:0] value);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(value);
	endtask

	// cut_at >= 0 drops the frame after that many payload bytes
	task automatic send_frame(input logic [LEN_W-1:0] len, input logic ack, input logic [6:0] cmd,
		input bit corrupt, input int junk, input int cut_at);
		logic [6:0] sum7;
		sum7 = len[6:0] + {ack, len[12:7]} + cmd;
		if (corrupt) sum7 = sum7 ^ 7'($urandom_range(1, 127));
		offer_byte(tracker.start_mark);
		offer_byte({1'($urandom_range(0, 1)), len[6:0]});
		offer_byte({1'($urandom_range(0, 1)), ack, len[12:7]});
		offer_byte({1'($urandom_range(0, 1)), cmd});
		for (int i = 0; i < len; i++) begin
			if (i == cut_at) return;
			offer_byte(8'($urandom));
		end
		offer_byte({1'($urandom_range(0, 1)), sum7});
		repeat (junk) offer_byte(byte_other_than(tracker.end_mark));
		offer_byte(tracker.end_mark);
	endtask

	task automatic resync();
		while (tracker.position != POS_IDLE) begin
			if (tracker.awaiting_end()) offer_byte(tracker.end_mark);
			else offer_byte(8'($urandom));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, value);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic random_traffic(input int budget);
		int first;
		int r;
		logic [LEN_W-1:0] len;
		first = tracker.bytes_seen;
		while (tracker.bytes_seen - first < budget) begin
			r = $urandom_range(0, 99);
			len = ($urandom_range(0, 99) < 3) ? LEN_W'($urandom_range(128, 300))
				: LEN_W'($urandom_range(0, 12));
			if (r < 75) begin
				send_frame(len, 1'($urandom_range(0, 1)), 7'($urandom),
					$urandom_range(0, 99) < 25,
					($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3), -1);
			end else if (r < 87) begin
				repeat ($urandom_range(1, 3)) offer_byte(byte_other_than(tracker.start_mark));
			end else begin
				len = LEN_W'($urandom_range(1, 8));
				send_frame(len, 1'($urandom_range(0, 1)), 7'($urandom), 1'b0, 0,
					$urandom_range(0, len - 1));
				send_frame(LEN_W'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
					7'($urandom), 1'b0, 0, -1);
				resync();
			end
		end
		resync();
	endtask

	task automatic set_markers(input logic [7:0] start_value, input logic [7:0] end_value);
		wait_drained();
		write_register(CFG_START_MARKER, start_value);
		write_register(CFG_END_MARKER, end_value);
		marker_settings++;
	endtask

	initial begin
		logic [7:0] m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		offer_byte(8'hFF);
		offer_byte(8'h00);
		send_frame(LEN_W'(0), 1'b0, 7'h7F, 1'b0, 0, -1);
		send_frame(LEN_W'(1), 1'b1, 7'h00, 1'b1, 2, -1);
		send_frame(LEN_W'(2), 1'b1, 7'h2A, 1'b0, 0, -1);
		random_traffic(PHASE_BYTES);

		set_markers(8'h00, 8'hFF);
		gapless = 1'b1;
		long_hold_req = 1'b1;
		send_frame(LEN_W'(60), 1'b1, 7'($urandom), 1'b0, 0, -1);
		gapless = 1'b0;
		random_traffic(PHASE_BYTES);

		set_markers(8'hFF, 8'h00);
		random_traffic(PHASE_BYTES);

		m = 8'($urandom);
		set_markers(m, m);
		random_traffic(PHASE_BYTES);

		set_markers(8'($urandom), 8'($urandom));
		send_frame(LEN_W'(255), 1'b1, 7'($urandom), 1'b0, 0, -1);
		random_traffic(PHASE_BYTES);

		wait_drained();
		$display("covered %0d input bytes: %0d payload beats, %0d good and %0d bad frames",
			tracker.bytes_seen, tracker.payload_count, tracker.good_count, tracker.bad_count);
		$display("%0d marker settings, with both extremes and equal start and end markers",
			marker_settings);
		if (tracker.errors == 0)
			$display("framed_packet_receiver_unit test passed");
		else
			$display("framed_packet_receiver_unit test failed");
		$finish;
	end

endmodule
